/* src/cep_pkg.sv */
// Shared types, constants and calendar functions for the calendar to epoch seconds block.
package cep_pkg;

  localparam int unsigned EpochYear  = 70;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned SecsPerHour = 3600;

  localparam int unsigned TodWidth  = 17;
  localparam int unsigned DaysWidth = 18;
  localparam int unsigned SecsWidth = 35;
  localparam int unsigned OutWidth  = 34;
  localparam int unsigned OffWidth  = 18;

  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic years_done;
  } status_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

  // Gregorian rule on the year 1900 + y; within 1900 to 2155 only 1900 and 2100 fail it.
  function automatic logic is_leap(input logic [7:0] y);
    return (y[1:0] == 2'd0) && (y != 8'd0) && (y != 8'd200);
  endfunction

  function automatic logic [TodWidth-1:0] tod(input logic [5:0] s, input logic [5:0] m,
                                                input logic [4:0] h);
    return TodWidth'(s) + TodWidth'(m) * TodWidth'(SecsPerMin)
         + TodWidth'(h) * TodWidth'(SecsPerHour);
  endfunction

endpackage

/* src/calendar_to_epoch_seconds.sv */
// Top level of the calendar to epoch seconds converter.
//
//   channel  signals                                         direction
//   in       in_valid, in_stall, second .. force_full        reading into the block
//   out      out_valid, out_stall, epoch_seconds, was_full   result out of the block
//   cfg      cfg_we, cfg_data                                epoch_offset write
//
// A full conversion runs the load, the year loop, the multiply and the finish step; the
// year loop adds one year of days per cycle. An incremental update skips the year loop
// and the multiply. A new reading is taken once the previous one has reached the result
// register, even while that result is still stalled. Reset clears the cache and the offset.
module calendar_to_epoch_seconds (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [17:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         second,
  input  logic [5:0]         minute,
  input  logic [4:0]         hour,
  input  logic [4:0]         day_of_month,
  input  logic [3:0]         month,
  input  logic [7:0]         year_since_1900,
  input  logic               force_full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] epoch_seconds,
  output logic               was_full
);

  cep_pkg::cmd_t    cmd;
  cep_pkg::status_t status;

  cep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cep_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .day_of_month    (day_of_month),
    .month           (month),
    .year_since_1900 (year_since_1900),
    .force_full      (force_full),
    .epoch_seconds   (epoch_seconds),
    .was_full        (was_full)
  );

endmodule

/* src/cep_ctrl.sv */
// Controller state machine that sequences one conversion at a time.
module cep_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  cep_pkg::status_t status,
  output cep_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_YEARS,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load = in_valid && !rst;
      S_YEARS:  cmd.step = status.full && !status.years_done;
      S_MUL:    cmd.mul = 1'b1;
      S_FINISH: cmd.finish = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_YEARS;
          end
        end
        S_YEARS: begin
          if (!status.full) begin
            state <= S_FINISH;
          end else if (status.years_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/cep_dp.sv */
// Datapath holding the reading, the day count, the cached time and the result register.
module cep_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cep_pkg::cmd_t                 cmd,
  output cep_pkg::status_t              status,
  input  logic                          cfg_we,
  input  logic signed [17:0]            cfg_data,
  input  logic [5:0]                    second,
  input  logic [5:0]                    minute,
  input  logic [4:0]                    hour,
  input  logic [4:0]                    day_of_month,
  input  logic [3:0]                    month,
  input  logic [7:0]                    year_since_1900,
  input  logic                          force_full,
  output logic signed [33:0]            epoch_seconds,
  output logic                          was_full
);

  localparam int unsigned DW = cep_pkg::DaysWidth;
  localparam int unsigned SW = cep_pkg::SecsWidth;
  localparam int unsigned TW = cep_pkg::TodWidth;

  logic signed [cep_pkg::OffWidth-1:0] epoch_offset;
  logic                                cache_valid;
  logic signed [SW-1:0]                cached_seconds;
  logic [5:0]                          cached_second;
  logic [5:0]                          cached_minute;
  logic [4:0]                          cached_hour;
  logic [4:0]                          cached_day;

  logic [4:0]           mday;
  logic [7:0]           year;
  logic [7:0]           ycnt;
  logic                 full;
  logic [TW-1:0]        tod_new;
  logic [TW-1:0]        tod_old;
  logic signed [DW-1:0] days;
  logic signed [SW-1:0] prod;

  logic [3:0]           mon_clamp;
  logic signed [DW-1:0] days_base;
  logic signed [SW-1:0] secs_next;

  assign status.full       = full;
  assign status.years_done = (ycnt >= year);

  always_comb begin
    mon_clamp = (month > 4'd11) ? 4'd11 : month;
    days_base = $signed(DW'(cep_pkg::month_start(mon_clamp)))
              + $signed(DW'((mon_clamp > 4'd1) && cep_pkg::is_leap(year_since_1900)))
              + $signed(DW'(day_of_month)) - DW'(1);
    if (full) begin
      secs_next = prod + $signed(SW'(tod_new)) + SW'(epoch_offset);
    end else begin
      secs_next = cached_seconds + $signed(SW'(tod_new)) - $signed(SW'(tod_old));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_offset <= '0;
      cache_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        epoch_offset <= cfg_data;
      end
      if (cmd.finish && full) begin
        cache_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mday    <= day_of_month;
      year    <= year_since_1900;
      ycnt    <= 8'(cep_pkg::EpochYear);
      full    <= !cache_valid || force_full || (day_of_month != cached_day);
      tod_new <= cep_pkg::tod(second, minute, hour);
      tod_old <= cep_pkg::tod(cached_second, cached_minute, cached_hour);
      days    <= days_base;
      cached_second <= second;
      cached_minute <= minute;
      cached_hour   <= hour;
    end
    if (cmd.step) begin
      days <= days + $signed(DW'(cep_pkg::DaysPerYear)) + $signed(DW'(cep_pkg::is_leap(ycnt)));
      ycnt <= ycnt + 8'd1;
    end
    if (cmd.mul) begin
      prod <= SW'(days) * $signed(SW'(cep_pkg::SecsPerDay));
    end
    if (cmd.finish) begin
      cached_seconds <= secs_next;
      if (full) begin
        cached_day <= mday;
      end
      epoch_seconds <= secs_next[cep_pkg::OutWidth-1:0];
      was_full      <= full;
    end
  end

endmodule
